// ===== rtl/msp_pkg.sv =====
// shared types and constants for the maze shortest path search unit
// no dependencies
`default_nettype none

package msp_pkg;

  localparam int CELLS  = 64;
  localparam int IDX_W  = 6;
  localparam int DIST_W = 7;
  localparam int QENT_W = IDX_W + DIST_W;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_GRID_ROWS = 3'd0,
    REG_GRID_COLS = 3'd1,
    REG_START_ROW = 3'd2,
    REG_START_COL = 3'd3,
    REG_GOAL_ROW  = 3'd4,
    REG_GOAL_COL  = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_POP,
    S_POPW,
    S_BDIR,
    S_BCHK,
    S_WALK_BEGIN,
    S_WALK_LD,
    S_EMIT,
    S_WDIR,
    S_WCHK,
    S_NOPATH
  } state_t;

  typedef struct packed {
    logic [3:0] grid_rows;
    logic [3:0] grid_cols;
    logic [2:0] start_row;
    logic [2:0] start_col;
    logic [2:0] goal_row;
    logic [2:0] goal_col;
  } cfg_t;

  typedef struct packed {
    logic       en;
    logic [5:0] addr;
  } wall_rd_t;

endpackage

`default_nettype wire

// ===== rtl/maze_shortest_path_search_unit.sv =====
// maze shortest path search unit top level: configuration registers, input
// beat decode, wall memory and search sequencer
// depends on msp_pkg, msp_wall_store, msp_search_core
//
// channel  signals                                     direction
// cfg      cfg_valid cfg_ready cfg_index cfg_data      in, always ready
// in       in_valid in_ready op cell_row cell_col ...  in, ready while idle
// out      out_valid out_ready found path_row ...      out, one beat per cell
//
// a load beat writes one cell's wall bits; a search runs a distance pass over
// the reachable cells and then a walk along the path cells; each neighbor
// check uses the single wall memory read port
// reset clears control state only; no clearing pass is needed
// a stalled output holds the walk; no new beat is taken until the search ends
`default_nettype none

module maze_shortest_path_search_unit
  import msp_pkg::*;
#(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [2:0]  cell_row,
  input  wire logic [2:0]  cell_col,
  input  wire logic        wall_right,
  input  wire logic        wall_down,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             found,
  output logic      [2:0]  path_row,
  output logic      [2:0]  path_col,
  output logic      [6:0]  path_cells,
  output logic             last
);

  cfg_t       cfg;
  wall_rd_t   wall_rd;
  logic [1:0] wall_rd_data;
  logic       core_idle, accept, load_en, search_start;

  assign cfg_ready    = 1'b1;
  assign in_ready     = core_idle;
  assign accept       = in_valid && in_ready;
  assign load_en      = accept && (op == OP_LOAD) &&
                        ({1'b0, cell_row} < 4'(MAX_ROWS)) && ({1'b0, cell_col} < 4'(MAX_COLS));
  assign search_start = accept && (op == OP_SEARCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_rows <= 4'd8;
      cfg.grid_cols <= 4'd8;
      cfg.start_row <= 3'd0;
      cfg.start_col <= 3'd0;
      cfg.goal_row  <= 3'd7;
      cfg.goal_col  <= 3'd7;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_ROWS: cfg.grid_rows <= cfg_data;
        REG_GRID_COLS: cfg.grid_cols <= cfg_data;
        REG_START_ROW: cfg.start_row <= cfg_data[2:0];
        REG_START_COL: cfg.start_col <= cfg_data[2:0];
        REG_GOAL_ROW:  cfg.goal_row  <= cfg_data[2:0];
        REG_GOAL_COL:  cfg.goal_col  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  msp_wall_store u_walls (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr ({cell_row, cell_col}),
    .wr_data ({wall_down, wall_right}),
    .rd      (wall_rd),
    .rd_data (wall_rd_data)
  );

  msp_search_core #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .start        (search_start),
    .cfg          (cfg),
    .idle         (core_idle),
    .wall_rd      (wall_rd),
    .wall_rd_data (wall_rd_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .path_row     (path_row),
    .path_col     (path_col),
    .path_cells   (path_cells),
    .last         (last)
  );

endmodule

`default_nettype wire

// ===== rtl/msp_wall_store.sv =====
// wall memory: one right bit and one down bit per cell, registered read
// depends on msp_pkg
`default_nettype none

module msp_wall_store
  import msp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [IDX_W-1:0]     wr_addr,
  input  wire logic [1:0]           wr_data,
  input  wire wall_rd_t             rd,
  output logic      [1:0]           rd_data
);

  logic [1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/msp_search_core.sv =====
// search sequencer: breadth-first distance pass from the end cell into a
// distance memory and queue memory, then a walk from the start emitting cells
// depends on msp_pkg, reads walls through msp_wall_store
`default_nettype none

module msp_search_core
  import msp_pkg::*;
#(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire cfg_t             cfg,
  output logic                  idle,
  output wall_rd_t              wall_rd,
  input  wire logic [1:0]       wall_rd_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  found,
  output logic      [2:0]       path_row,
  output logic      [2:0]       path_col,
  output logic      [6:0]       path_cells,
  output logic                  last
);

  state_t state, state_next;

  logic [CELLS-1:0]  visited;
  logic [IDX_W:0]    head, tail;
  logic [IDX_W-1:0]  cur, nb, nb_q;
  logic [DIST_W-1:0] curd, count;
  dir_t              dir;
  logic              geo_ok, geo_q;

  logic [DIST_W-1:0] dist_mem [CELLS];
  logic [DIST_W-1:0] dist_rdata;
  logic [IDX_W-1:0]  dist_raddr;
  logic [QENT_W-1:0] queue_mem [CELLS];
  logic [QENT_W-1:0] q_rdata;

  logic [3:0]        rows_eff, cols_eff;
  logic              cfg_bad;
  logic [IDX_W-1:0]  start_idx, goal_idx;
  logic [IDX_W-1:0]  wall_addr;
  logic              wall_bit, push, move_ok, out_free, out_load, dir_last;
  logic              do_init, do_pop;

  assign rows_eff  = (cfg.grid_rows > 4'(MAX_ROWS)) ? 4'(MAX_ROWS) : cfg.grid_rows;
  assign cols_eff  = (cfg.grid_cols > 4'(MAX_COLS)) ? 4'(MAX_COLS) : cfg.grid_cols;
  assign cfg_bad   = (rows_eff == 4'd0) || (cols_eff == 4'd0) ||
                     ({1'b0, cfg.start_row} >= rows_eff) || ({1'b0, cfg.start_col} >= cols_eff) ||
                     ({1'b0, cfg.goal_row} >= rows_eff) || ({1'b0, cfg.goal_col} >= cols_eff);
  assign start_idx = {cfg.start_row, cfg.start_col};
  assign goal_idx  = {cfg.goal_row, cfg.goal_col};

  // neighbor geometry for the current direction
  always_comb begin
    geo_ok    = 1'b0;
    nb        = cur;
    wall_addr = cur;
    unique case (dir)
      DIR_RIGHT: begin
        geo_ok    = ({1'b0, cur[2:0]} + 4'd1) < cols_eff;
        nb        = {cur[5:3], cur[2:0] + 3'd1};
        wall_addr = cur;
      end
      DIR_LEFT: begin
        geo_ok    = cur[2:0] != 3'd0;
        nb        = {cur[5:3], cur[2:0] - 3'd1};
        wall_addr = nb;
      end
      DIR_DOWN: begin
        geo_ok    = ({1'b0, cur[5:3]} + 4'd1) < rows_eff;
        nb        = {cur[5:3] + 3'd1, cur[2:0]};
        wall_addr = cur;
      end
      DIR_UP: begin
        geo_ok    = cur[5:3] != 3'd0;
        nb        = {cur[5:3] - 3'd1, cur[2:0]};
        wall_addr = nb;
      end
      default: begin
        geo_ok = 1'b0;
      end
    endcase
  end

  assign wall_bit = (dir == DIR_RIGHT || dir == DIR_LEFT) ? wall_rd_data[0] : wall_rd_data[1];
  assign dir_last = dir == DIR_UP;
  assign out_free = !out_valid || out_ready;
  assign push     = (state == S_BCHK) && geo_q && !wall_bit && !visited[nb_q];
  assign move_ok  = geo_q && !wall_bit && visited[nb_q] && ((dist_rdata + 7'd1) == curd);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (start) state_next = cfg_bad ? S_NOPATH : S_INIT;
      S_INIT:       state_next = S_POP;
      S_POP:        state_next = (head == tail) ? S_WALK_BEGIN : S_POPW;
      S_POPW:       state_next = S_BDIR;
      S_BDIR:       state_next = S_BCHK;
      S_BCHK:       state_next = dir_last ? S_POP : S_BDIR;
      S_WALK_BEGIN: state_next = visited[start_idx] ? S_WALK_LD : S_NOPATH;
      S_WALK_LD:    state_next = S_EMIT;
      S_EMIT:       if (out_free) state_next = (curd == '0) ? S_IDLE : S_WDIR;
      S_WDIR:       state_next = S_WCHK;
      S_WCHK:       state_next = move_ok ? S_EMIT : S_WDIR;
      S_NOPATH:     if (out_free) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    idle       = state == S_IDLE;
    do_init    = state == S_INIT;
    do_pop     = (state == S_POP) && (head != tail);
    out_load   = ((state == S_EMIT) || (state == S_NOPATH)) && out_free;
    wall_rd.en   = (state == S_BDIR) || (state == S_WDIR);
    wall_rd.addr = wall_addr;
    dist_raddr = (state == S_WALK_BEGIN) ? start_idx : nb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
      head    <= '0;
      tail    <= '0;
      dir     <= DIR_RIGHT;
    end else begin
      if (do_init) begin
        visited <= {{(CELLS-1){1'b0}}, 1'b1} << goal_idx;
        head    <= '0;
        tail    <= (IDX_W+1)'(1);
      end
      if (do_pop) begin
        head <= head + 1'b1;
      end
      if (push) begin
        visited[nb_q] <= 1'b1;
        tail          <= tail + 1'b1;
      end
      if (state == S_POPW || state == S_EMIT) begin
        dir <= DIR_RIGHT;
      end else if (state == S_BCHK || (state == S_WCHK && !move_ok)) begin
        dir <= dir_t'(2'(dir) + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_BDIR || state == S_WDIR) begin
      nb_q  <= nb;
      geo_q <= geo_ok;
    end
    if (state == S_POPW) begin
      cur  <= q_rdata[IDX_W-1:0];
      curd <= q_rdata[QENT_W-1:IDX_W];
    end else if (state == S_WALK_LD) begin
      cur   <= start_idx;
      curd  <= dist_rdata;
      count <= dist_rdata + 7'd1;
    end else if (state == S_WCHK && move_ok) begin
      cur  <= nb_q;
      curd <= curd - 7'd1;
    end
  end

  // distance and queue memories
  always_ff @(posedge clk) begin
    if (do_init) begin
      dist_mem[goal_idx]   <= '0;
      queue_mem[6'd0]      <= {7'd0, goal_idx};
    end else if (push) begin
      dist_mem[nb_q]           <= curd + 7'd1;
      queue_mem[tail[IDX_W-1:0]] <= {curd + 7'd1, nb_q};
    end
    dist_rdata <= dist_mem[dist_raddr];
    q_rdata    <= queue_mem[head[IDX_W-1:0]];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == S_NOPATH) begin
        found      <= 1'b0;
        path_row   <= 3'd0;
        path_col   <= 3'd0;
        path_cells <= 7'd0;
        last       <= 1'b1;
      end else begin
        found      <= 1'b1;
        path_row   <= cur[5:3];
        path_col   <= cur[2:0];
        path_cells <= count;
        last       <= curd == '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    tail <= (IDX_W+1)'(CELLS))
    else $error("queue tail beyond cell count");

  a_head_le_tail: assert property (@(posedge clk) disable iff (rst)
    head <= tail)
    else $error("queue head passed tail");

  a_push_marks: assert property (@(posedge clk) disable iff (rst)
    push |=> visited[$past(nb_q)])
    else $error("pushed cell not marked visited");

  a_walk_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_WCHK && dir == DIR_UP) |-> move_ok)
    else $error("walk found no neighbor one step closer");
`endif

endmodule

`default_nettype wire
